// ===== rtl/core/u8sd_pkg.sv =====
// Shared types and constants for the streaming UTF-8 decoder.
// Holds result kinds, the result record and the queue push bundle.
// No dependencies.
package u8sd_pkg;

  // Byte classification masks and tags
  localparam logic [7:0] LEAD_MASK    = 8'hC0;
  localparam logic [7:0] CONT_TAG     = 8'h80;
  localparam logic [7:0] PAYLOAD_MASK = 8'h3F;
  localparam int unsigned PAYLOAD_BITS = 6;

  localparam int unsigned CP_W    = 32;
  localparam int unsigned RAW_W   = 64;
  localparam int unsigned COUNT_W = 4;

  // Result queue geometry: room for one waiting beat plus a two-result burst
  localparam int unsigned OUTQ_DEPTH = 3;
  localparam int unsigned OUTQ_PTR_W = 2;

  typedef logic [OUTQ_PTR_W-1:0] qptr_t;

  typedef enum logic [1:0] {
    KIND_ASCII   = 2'd0,
    KIND_CODE    = 2'd1,
    KIND_INVALID = 2'd2,
    KIND_END     = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [CP_W-1:0]    code_point;
    logic [RAW_W-1:0]   raw_bytes;
    logic [COUNT_W-1:0] raw_count;
    logic               last;
  } result_t;

  // Up to two results produced by one input beat, in delivery order
  typedef struct packed {
    logic [1:0] num;
    result_t    first;
    result_t    second;
  } push_t;

  function automatic qptr_t qptr_inc(input qptr_t p);
    qptr_t r;
    r = (p == qptr_t'(OUTQ_DEPTH - 1)) ? '0 : qptr_t'(p + qptr_t'(1));
    return r;
  endfunction

endpackage

// ===== rtl/core/utf8_stream_decoder_core.sv =====
// Streaming UTF-8 decoder top level: one text byte or end mark per beat.
// Results are registered in the queue and offered from its head on the output.
// Throughput: one input beat per cycle while at most one result is queued;
// a two-result beat stalls input; the queue gives at most one result per cycle.
// Reset: asynchronous, active low; clears sequence state and empties the queue.
module utf8_stream_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  text_byte_i,
  input  logic        end_of_text_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [31:0] code_point_o,
  output logic [63:0] raw_bytes_o,
  output logic [3:0]  raw_count_o,
  output logic        last_o
);
  import u8sd_pkg::*;

  logic       accept;
  logic       pop;
  logic       busy;
  logic [1:0] level;
  push_t      push;
  result_t    head;

  // Accept only while the queue has room for a two-result burst. The check
  // looks at the registered level alone, so ready never depends on the
  // output side in the same cycle.
  assign in_ready_o  = (level <= 2'd1);
  assign accept      = in_valid_i && in_ready_o;

  // Hand out the head entry whenever the queue holds anything
  assign out_valid_o = (level != 2'd0);
  assign pop         = out_valid_o && out_ready_i;

  assign kind_o       = head.kind;
  assign code_point_o = head.code_point;
  assign raw_bytes_o  = head.raw_bytes;
  assign raw_count_o  = head.raw_count;
  assign last_o       = head.last;

  // Classify the beat, advance the sequence state, build its results
  u8sd_step u_step (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .text_byte_i   (text_byte_i),
    .end_of_text_i (end_of_text_i),
    .push_o        (push),
    .busy_o        (busy)
  );

  // Hold results until the consumer takes them
  u8sd_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .level_o (level)
  );

`ifndef SYNTHESIS
  // The queue never holds more than its depth
  a_level_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    level <= 2'(OUTQ_DEPTH))
    else $error("result queue overflow");

  // A two-result burst is always a cut sequence followed by the closing result
  a_burst_shape : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.num == 2'd2 |-> (push.first.kind == KIND_INVALID) && !push.first.last
                         && push.second.last)
    else $error("malformed two-result burst");

  // End of text leaves no sequence pending
  a_end_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && end_of_text_i |=> !busy)
    else $error("sequence still pending after end of text");

  // An end result always closes its beat
  a_end_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (kind_o == KIND_END) |-> last_o)
    else $error("end result without last");
`endif

endmodule

// ===== rtl/core/u8sd_step.sv =====
// Sequence tracker: classifies each input beat, updates the pending
// sequence state and builds the results it causes. Uses u8sd_pkg.
module u8sd_step (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       text_byte_i,
  input  logic             end_of_text_i,
  output u8sd_pkg::push_t  push_o,
  output logic             busy_o
);
  import u8sd_pkg::*;

  logic [COUNT_W-1:0] exp_len_q, exp_len_d;
  logic [COUNT_W-1:0] cnt_q, cnt_d;
  logic [CP_W-1:0]    acc_q, acc_d;
  logic [RAW_W-1:0]   store_q, store_d;

  logic               pending;
  logic               is_ascii;
  logic               is_lead;
  logic [COUNT_W-1:0] ones;
  logic [7:0]         seed;
  logic [RAW_W-1:0]   store_push;
  logic [COUNT_W-1:0] cnt_push;
  logic [CP_W-1:0]    acc_push;
  result_t            flush_res;
  result_t            tail_res;

  assign pending  = (exp_len_q != '0);
  assign is_ascii = ~text_byte_i[7];
  assign is_lead  = ((text_byte_i & LEAD_MASK) == LEAD_MASK);
  assign busy_o   = pending;

  // Count leading ones of the lead byte
  always_comb begin
    logic found;
    found = 1'b0;
    ones  = '0;
    for (int i = 7; i >= 0; i--) begin
      if (!found) begin
        if (text_byte_i[i]) begin
          ones = COUNT_W'(ones + COUNT_W'(1));
        end else begin
          found = 1'b1;
        end
      end
    end
  end

  assign seed = text_byte_i & (8'hFF >> ones);

  // Continuation byte appended to the pending sequence
  always_comb begin
    store_push = store_q;
    cnt_push   = cnt_q;
    if (cnt_q < COUNT_W'(8)) begin
      store_push = store_q | ({{(RAW_W-8){1'b0}}, text_byte_i} << {cnt_q[2:0], 3'b000});
      cnt_push   = COUNT_W'(cnt_q + COUNT_W'(1));
    end
  end

  assign acc_push = {acc_q[CP_W-1-PAYLOAD_BITS:0], text_byte_i[PAYLOAD_BITS-1:0]};

  always_comb begin
    flush_res            = '0;
    flush_res.kind       = KIND_INVALID;
    flush_res.raw_bytes  = store_q;
    flush_res.raw_count  = cnt_q;
    flush_res.last       = 1'b0;
    tail_res             = '0;
    if (end_of_text_i) begin
      tail_res.kind       = KIND_END;
    end else begin
      tail_res.kind       = KIND_ASCII;
      tail_res.code_point = {{(CP_W-8){1'b0}}, text_byte_i};
      tail_res.raw_bytes  = {{(RAW_W-8){1'b0}}, text_byte_i};
      tail_res.raw_count  = COUNT_W'(1);
    end
    tail_res.last = 1'b1;
  end

  always_comb begin
    exp_len_d = exp_len_q;
    cnt_d     = cnt_q;
    acc_d     = acc_q;
    store_d   = store_q;
    push_o    = '0;
    if (accept_i) begin
      if (end_of_text_i || is_ascii) begin
        // Flush any cut sequence, then the ASCII or end result
        exp_len_d = '0;
        cnt_d     = '0;
        acc_d     = '0;
        store_d   = '0;
        if (pending) begin
          push_o.num    = 2'd2;
          push_o.first  = flush_res;
          push_o.second = tail_res;
        end else begin
          push_o.num   = 2'd1;
          push_o.first = tail_res;
        end
      end else if (is_lead) begin
        exp_len_d = ones;
        cnt_d     = COUNT_W'(1);
        acc_d     = {{(CP_W-8){1'b0}}, seed};
        store_d   = {{(RAW_W-8){1'b0}}, text_byte_i};
        if (pending) begin
          push_o.num        = 2'd1;
          push_o.first      = flush_res;
          push_o.first.last = 1'b1;
        end
      end else if (pending) begin
        if (cnt_push == exp_len_q) begin
          push_o.num              = 2'd1;
          push_o.first.kind       = KIND_CODE;
          push_o.first.code_point = acc_push;
          push_o.first.raw_bytes  = store_push;
          push_o.first.raw_count  = cnt_push;
          push_o.first.last       = 1'b1;
          exp_len_d = '0;
          cnt_d     = '0;
          acc_d     = '0;
          store_d   = '0;
        end else begin
          cnt_d   = cnt_push;
          acc_d   = acc_push;
          store_d = store_push;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_len_q <= '0;
      cnt_q     <= '0;
      acc_q     <= '0;
      store_q   <= '0;
    end else begin
      exp_len_q <= exp_len_d;
      cnt_q     <= cnt_d;
      acc_q     <= acc_d;
      store_q   <= store_d;
    end
  end

endmodule

// ===== rtl/core/u8sd_outq.sv =====
// Three-entry result queue: takes up to two results per cycle, hands out
// one per output beat from a registered head. Uses u8sd_pkg.
module u8sd_outq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  u8sd_pkg::push_t   push_i,
  input  logic              pop_i,
  output u8sd_pkg::result_t head_o,
  output logic [1:0]        level_o
);
  import u8sd_pkg::*;

  result_t    mem_q [OUTQ_DEPTH];
  qptr_t      rptr_q, rptr_d;
  qptr_t      wptr_q, wptr_d;
  logic [1:0] level_q, level_d;
  qptr_t      wptr_next;

  assign wptr_next = qptr_inc(wptr_q);
  assign head_o    = mem_q[rptr_q];
  assign level_o   = level_q;

  always_comb begin
    rptr_d  = pop_i ? qptr_inc(rptr_q) : rptr_q;
    wptr_d  = wptr_q;
    if (push_i.num == 2'd1) begin
      wptr_d = wptr_next;
    end else if (push_i.num == 2'd2) begin
      wptr_d = qptr_inc(wptr_next);
    end
    level_d = 2'(level_q + push_i.num - {1'b0, pop_i});
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wptr_q] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wptr_next] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rptr_q  <= '0;
      wptr_q  <= '0;
      level_q <= '0;
    end else begin
      rptr_q  <= rptr_d;
      wptr_q  <= wptr_d;
      level_q <= level_d;
    end
  end

endmodule

// ===== tb/utf8_decoder_checker.sv =====
// Scoreboard for the streaming UTF-8 decoder: watches both channels,
// predicts the result beats of every accepted text beat and compares them.
// Depends on u8sd_pkg for the result record, result kinds and byte masks.
module utf8_decoder_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  text_byte_i,
  input  logic        end_of_text_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  kind_i,
  input  logic [31:0] code_point_i,
  input  logic [63:0] raw_bytes_i,
  input  logic [3:0]  raw_count_i,
  input  logic        last_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_o
);
  import u8sd_pkg::*;

  // Decoder state as the predictor tracks it
  logic [3:0]  seq_len;
  logic [31:0] cp_acc;
  logic [63:0] seq_bytes;
  logic [3:0]  seq_count;

  result_t expected_results[$];
  int      fail_total;
  int      result_total;

  function automatic result_t make_result(input kind_e k, input logic [31:0] cp,
                                          input logic [63:0] raw, input logic [3:0] cnt);
    result_t r;
    r.kind       = k;
    r.code_point = cp;
    r.raw_bytes  = raw;
    r.raw_count  = cnt;
    r.last       = 1'b0;
    return r;
  endfunction

  // Append one predicted beat at the tail of the expected list
  task automatic queue_expected(input result_t r);
    expected_results = {expected_results, r};
  endtask

  task automatic clear_sequence();
    seq_len   = '0;
    cp_acc    = '0;
    seq_bytes = '0;
    seq_count = '0;
  endtask

  // Emit an invalid beat for a sequence that is cut short
  task automatic flush_cut_sequence(inout int n);
    if (seq_len != 0) begin
      queue_expected(make_result(KIND_INVALID, '0, seq_bytes, seq_count));
      clear_sequence();
      n++;
    end
  endtask

  task automatic decode_text_beat(input logic [7:0] b, input logic eot);
    int n;
    int ones;
    n = 0;
    if (eot) begin
      flush_cut_sequence(n);
      queue_expected(make_result(KIND_END, '0, '0, '0));
      n++;
    end else if (b < CONT_TAG) begin
      flush_cut_sequence(n);
      queue_expected(make_result(KIND_ASCII, 32'(b), 64'(b), 4'd1));
      n++;
    end else if ((b & LEAD_MASK) == LEAD_MASK) begin
      flush_cut_sequence(n);
      ones = 0;
      while (ones < 8 && b[7 - ones]) ones++;
      seq_len   = 4'(ones);
      cp_acc    = (ones >= 8) ? '0 : 32'(b & (8'hFF >> ones));
      seq_bytes = 64'(b);
      seq_count = 4'd1;
    end else if (seq_len != 0) begin
      if (seq_count < 8) begin
        seq_bytes = seq_bytes | (64'(b) << (8 * seq_count));
        seq_count = seq_count + 4'd1;
      end
      cp_acc = {cp_acc[31-PAYLOAD_BITS:0], b[PAYLOAD_BITS-1:0]};
      if (seq_count == seq_len) begin
        queue_expected(make_result(KIND_CODE, cp_acc, seq_bytes, seq_count));
        clear_sequence();
        n++;
      end
    end
    // Flag the final beat caused by this input
    if (n > 0) expected_results[expected_results.size() - 1].last = 1'b1;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_total++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      clear_sequence();
      expected_results.delete();
      fail_total   = 0;
      result_total = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      results_o    <= 0;
    end else begin
      if (in_valid_i && in_ready_i) decode_text_beat(text_byte_i, end_of_text_i);
      if (out_valid_i && out_ready_i) begin
        result_total++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual kind %0d cp %h",
                   $time, kind_i, code_point_i);
          fail_total++;
        end else begin
          want = expected_results.pop_front();
          check_field("kind", 64'(want.kind), 64'(kind_i));
          check_field("code_point", 64'(want.code_point), 64'(code_point_i));
          check_field("raw_bytes", want.raw_bytes, raw_bytes_i);
          check_field("raw_count", 64'(want.raw_count), 64'(raw_count_i));
          check_field("last", 64'(want.last), 64'(last_i));
        end
      end
      fail_count_o <= fail_total;
      pending_o    <= expected_results.size();
      results_o    <= result_total;
    end
  end

endmodule

// ===== tb/tb_utf8_stream_decoder_core.sv =====
// Top of the UTF-8 stream decoder testbench: clock, reset, text stimulus,
// output back-pressure and the verdict. Depends on utf8_stream_decoder_core
// and utf8_decoder_checker, which predicts and compares every result beat.
module tb_utf8_stream_decoder_core;

  localparam int RANDOM_ITEMS = 1500;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 1000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  text_byte = 8'h00;
  logic        end_of_text = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic [31:0] code_point;
  logic [63:0] raw_bytes;
  logic [3:0]  raw_count;
  logic        last;

  int fail_count;
  int pending;
  int results;
  int beats_sent = 0;
  int cycles = 0;
  // Set by the stimulus, consumed by the ready generator
  int hold_cycles_req = 0;
  bit no_idle = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  utf8_stream_decoder_core DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .text_byte_i   (text_byte),
    .end_of_text_i (end_of_text),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .kind_o        (kind),
    .code_point_o  (code_point),
    .raw_bytes_o   (raw_bytes),
    .raw_count_o   (raw_count),
    .last_o        (last)
  );

  utf8_decoder_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .text_byte_i   (text_byte),
    .end_of_text_i (end_of_text),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .kind_i        (kind),
    .code_point_i  (code_point),
    .raw_bytes_i   (raw_bytes),
    .raw_count_i   (raw_count),
    .last_i        (last),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .results_o     (results)
  );

  // Stop a hung run: count cycles and bail out well past any sane runtime
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycles, pending);
      $display("tb_utf8_stream_decoder_core NOT OK");
      $finish;
    end
  end

  // Gap lengths: mostly none or short, now and then a long one
  function automatic int idle_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(80, 30);
  endfunction

  // Sequence lengths: favor the common 2..4 byte forms, keep 5..8 in the mix
  function automatic int seq_length();
    int r;
    r = $urandom_range(99);
    if (r < 40) return 2;
    if (r < 70) return 3;
    if (r < 85) return 4;
    return $urandom_range(8, 5);
  endfunction

  // Ready generator: random stalls, plus one long hold-off on request.
  // The hold is counted here so the sender keeps offering beats meanwhile.
  initial begin : ready_gen
    int gap_left;
    int hold_left;
    gap_left  = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles_req > 0) begin
        hold_left       = hold_cycles_req;
        hold_cycles_req = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (gap_left > 0) begin
        out_ready <= 1'b0;
        gap_left--;
      end else begin
        out_ready <= 1'b1;
        if (!no_idle && $urandom_range(3) == 0) gap_left = idle_gap();
      end
    end
  end

  // Offer one beat after an optional gap and hold it until accepted.
  // With no gap, valid stays high into the next beat without a dip.
  task automatic send_text_beat(input logic [7:0] b, input logic eot);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    text_byte   <= b;
    end_of_text <= eot;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  // Lead byte of a given length plus (nbytes - 1) continuation bytes
  task automatic send_sequence(input int len, input int nbytes);
    logic [7:0] lead;
    lead = (8'hFF << (8 - len)) | (8'($urandom) & (8'hFF >> (len + 1)));
    send_text_beat(lead, 1'b0);
    for (int i = 1; i < nbytes; i++) send_text_beat(8'h80 | 8'($urandom_range(63)), 1'b0);
  endtask

  // Drop valid and hold until every expected result has come back
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin : stimulus
    int items;
    int pick;
    int len;
    bit hold_done;
    bit pause_done;
    items      = 0;
    hold_done  = 1'b0;
    pause_done = 1'b0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: ascii extremes
    send_text_beat(8'h00, 1'b0);
    send_text_beat(8'h7F, 1'b0);
    // Complete 2- and 3-byte code points
    send_text_beat(8'hC3, 1'b0);
    send_text_beat(8'hA9, 1'b0);
    send_text_beat(8'hE2, 1'b0);
    send_text_beat(8'h82, 1'b0);
    send_text_beat(8'hAC, 1'b0);
    // Lead 0xFF: eight bytes, zero seed, accumulator wraps
    send_text_beat(8'hFF, 1'b0);
    send_text_beat(8'h80, 1'b0);
    send_text_beat(8'hBF, 1'b0);
    send_text_beat(8'hAA, 1'b0);
    send_text_beat(8'h95, 1'b0);
    send_text_beat(8'hBF, 1'b0);
    send_text_beat(8'h80, 1'b0);
    send_text_beat(8'hBF, 1'b0);
    // Stray continuation with nothing pending: dropped
    send_text_beat(8'h80, 1'b0);
    // Sequence cut by an ascii byte
    send_text_beat(8'hE2, 1'b0);
    send_text_beat(8'h82, 1'b0);
    send_text_beat(8'h41, 1'b0);
    // Sequence cut by a new lead, then the new one cut by end of text;
    // the byte under the end mark is ignored
    send_text_beat(8'hC3, 1'b0);
    send_text_beat(8'hFE, 1'b0);
    send_text_beat(8'hA5, 1'b1);
    // End of text with nothing pending
    send_text_beat(8'h00, 1'b1);
    wait_drain();

    // Random: mostly well-formed text, some cut sequences and noise
    while (items < RANDOM_ITEMS) begin
      if (items >= 400 && !hold_done) begin
        hold_cycles_req = HOLD_CYCLES;
        hold_done       = 1'b1;
      end
      if (items >= 800 && !pause_done) begin
        wait_drain();
        pause_done = 1'b1;
      end
      no_idle = (items >= 1000 && items < 1200);
      pick = $urandom_range(99);
      if (pick < 35) begin
        send_text_beat(8'($urandom_range(127)), 1'b0);
        items++;
      end else if (pick < 75) begin
        len = seq_length();
        send_sequence(len, len);
        items += len;
      end else if (pick < 87) begin
        len = seq_length();
        send_sequence(len, $urandom_range(len - 1, 1));
        items++;
      end else if (pick < 95) begin
        // Noise: any byte, often a stray continuation
        send_text_beat(8'($urandom_range(255)), 1'b0);
      end else begin
        send_text_beat(8'($urandom_range(255)), 1'b1);
        items++;
      end
    end
    no_idle = 1'b0;

    wait_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d text beats, checked %0d result beats: ascii, 2..8 byte sequences,",
             beats_sent, results);
    $display("cut and stray sequences, end marks, a %0d-cycle output hold and a drain pause.",
             HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_utf8_stream_decoder_core OK");
    end else begin
      $display("tb_utf8_stream_decoder_core NOT OK");
    end
    $finish;
  end

endmodule
